[rtl/core/utc_pkg.sv]
// utc_pkg: format codes, register indexes, constants and shared types of the
// unicode transcoder. No dependencies; the transcoder modules and the testbench import it.
`default_nettype none

package utc_pkg;

  localparam logic [3:0] FMT_ASCII   = 4'd0;
  localparam logic [3:0] FMT_LATIN1  = 4'd1;
  localparam logic [3:0] FMT_UTF8    = 4'd2;
  localparam logic [3:0] FMT_UTF16   = 4'd3;
  localparam logic [3:0] FMT_UTF16BE = 4'd4;
  localparam logic [3:0] FMT_UTF16LE = 4'd5;
  localparam logic [3:0] FMT_UTF32   = 4'd6;
  localparam logic [3:0] FMT_UTF32BE = 4'd7;
  localparam logic [3:0] FMT_UTF32LE = 4'd8;
  localparam logic [3:0] FMT_UCS2BE  = 4'd9;
  localparam logic [3:0] FMT_UCS2LE  = 4'd10;
  localparam logic [3:0] FMT_UCS4BE  = 4'd11;
  localparam logic [3:0] FMT_UCS4LE  = 4'd12;

  localparam logic [1:0] CFG_SRC_FORMAT    = 2'd0;
  localparam logic [1:0] CFG_DST_FORMAT    = 2'd1;
  localparam logic [1:0] CFG_NATIVE_LITTLE = 2'd2;

  localparam logic [31:0] REPL_CP   = 32'h0000_FFFD;
  localparam logic [31:0] MAX_CP    = 32'h0010_FFFF;
  localparam logic [31:0] MARK_CP   = 32'h0000_FEFF;
  localparam logic [31:0] UCS4_MAX  = 32'h7FFF_FFFF;
  localparam logic [31:0] SURR_LO   = 32'h0000_D800;
  localparam logic [31:0] SURR_HI   = 32'h0000_DFFF;
  localparam logic [31:0] HIGH_LAST = 32'h0000_DBFF;
  localparam logic [31:0] LOW_FIRST = 32'h0000_DC00;
  localparam logic [31:0] PLANE1    = 32'h0001_0000;
  localparam logic [7:0]  QMARK     = 8'h3F;

  typedef struct packed {
    logic [3:0] src_format;
    logic [3:0] dst_format;
    logic       native_little;
  } cfg_t;

  // what one source byte produces, in output order: mark, cp0, cp1, truncation
  typedef struct packed {
    logic        mark;
    logic        v0;
    logic [31:0] cp0;
    logic        v1;
    logic [31:0] cp1;
    logic        trunc;
  } evt_t;

  function automatic logic is_surr(input logic [31:0] c);
    return (c >= SURR_LO) && (c <= SURR_HI);
  endfunction

endpackage

`default_nettype wire

[rtl/core/utc_in_if.sv]
// utc_in_if: source byte channel of the unicode transcoder.
// Valid/ready handshake with in_byte and in_last; no dependencies.
`default_nettype none

interface utc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

[rtl/core/utc_out_if.sv]
// utc_out_if: destination byte channel of the unicode transcoder.
// Valid/ready handshake with out_byte, char_end and status; no dependencies.
`default_nettype none

interface utc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       char_end;
  logic       status;

  modport source (output valid, output out_byte, output char_end, output status, input ready);
  modport sink   (input valid, input out_byte, input char_end, input status, output ready);
endinterface

`default_nettype wire

[rtl/core/unicode_transcoder.sv]
// unicode_transcoder: top level, configuration registers and the decoder and
// serializer pipeline. Depends on utc_pkg, utc_in_if, utc_out_if, utc_decoder,
// utc_serializer.
//
// Source bytes are accepted one per cycle into the decoder while its event
// register is free or being taken, and the decoder registers the code points
// that each byte completes. The serializer then sends the destination bytes
// one per cycle while the output is ready: 1 to 4 per character, plus up to 4
// for the byte order mark and 1 for a truncation transaction. A configuration
// write restarts the text; the user must make it only while the block is idle,
// the block itself does not enforce it.
`default_nettype none

module unicode_transcoder import utc_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        cfg_we,
  input  wire  [1:0] cfg_index,
  input  wire  [3:0] cfg_data,
  utc_in_if.sink     in_ch,
  utc_out_if.source  out_ch
);

  cfg_t cfg_r;
  logic stream_clear;
  logic evt_valid;
  evt_t evt;
  logic evt_ready;

  assign stream_clear = cfg_we && (cfg_index == CFG_SRC_FORMAT ||
                                   cfg_index == CFG_DST_FORMAT ||
                                   cfg_index == CFG_NATIVE_LITTLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_format    <= FMT_UTF8;
      cfg_r.dst_format    <= FMT_UTF8;
      cfg_r.native_little <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SRC_FORMAT:    cfg_r.src_format    <= cfg_data;
        CFG_DST_FORMAT:    cfg_r.dst_format    <= cfg_data;
        CFG_NATIVE_LITTLE: cfg_r.native_little <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  utc_decoder u_decoder (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .stream_clear (stream_clear),
    .in_ch        (in_ch),
    .evt_valid    (evt_valid),
    .evt          (evt),
    .evt_ready    (evt_ready)
  );

  utc_serializer u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .evt_valid (evt_valid),
    .evt       (evt),
    .evt_ready (evt_ready),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

[rtl/core/utc_decoder.sv]
// utc_decoder: collects source bytes into characters and decodes them to code
// points, one byte per cycle while the event register is free, into an event register. Depends on utc_pkg, utc_in_if.
`default_nettype none

module utc_decoder import utc_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  cfg_t        cfg,
  input  wire         stream_clear,
  utc_in_if.sink      in_ch,
  output logic        evt_valid,
  output evt_t        evt,
  input  wire         evt_ready
);

  logic [31:0] code_accum_r, code_accum_nxt;
  logic [1:0]  cont_left_r, cont_left_nxt;
  logic [1:0]  unit_count_r, unit_count_nxt;
  logic        overlong_r, overlong_nxt;
  logic [9:0]  high_surr_r, high_surr_nxt;
  logic        have_high_r, have_high_nxt;
  logic        src_le_r, src_le_nxt;
  logic        started_r, started_nxt;
  logic        evt_valid_r;
  evt_t        evt_r, evt_nxt;
  logic        accept;
  logic        dst_generic;

  function automatic evt_t push_cp(input evt_t e, input logic [31:0] cp);
    evt_t r;
    r = e;
    if (!r.v0) begin
      r.v0  = 1'b1;
      r.cp0 = cp;
    end else begin
      r.v1  = 1'b1;
      r.cp1 = cp;
    end
    return r;
  endfunction

  assign in_ch.ready = !evt_valid_r || evt_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign dst_generic = (cfg.dst_format == FMT_UTF16) || (cfg.dst_format == FMT_UTF32);
  assign evt_valid   = evt_valid_r;
  assign evt         = evt_r;

  always_comb begin
    logic [7:0]  b;
    logic        handled;
    logic        size4;
    logic [2:0]  cnt;
    logic [31:0] cp;
    logic [31:0] raw;
    logic [31:0] v;
    logic        le;
    b              = in_ch.in_byte;
    handled        = 1'b0;
    size4          = 1'b0;
    cnt            = 3'd0;
    cp             = 32'd0;
    raw            = 32'd0;
    v              = 32'd0;
    le             = 1'b0;
    code_accum_nxt = code_accum_r;
    cont_left_nxt  = cont_left_r;
    unit_count_nxt = unit_count_r;
    overlong_nxt   = overlong_r;
    high_surr_nxt  = high_surr_r;
    have_high_nxt  = have_high_r;
    src_le_nxt     = src_le_r;
    started_nxt    = started_r;
    evt_nxt        = '0;
    unique case (cfg.src_format)
      FMT_ASCII, FMT_LATIN1: begin
        if (!started_nxt) evt_nxt.mark = dst_generic;
        started_nxt = 1'b1;
        evt_nxt = push_cp(evt_nxt, {24'd0, (cfg.src_format == FMT_ASCII) ? {1'b0, b[6:0]} : b});
      end
      FMT_UTF8: begin
        if (!started_nxt) evt_nxt.mark = dst_generic;
        started_nxt = 1'b1;
        if (cont_left_nxt != 2'd0) begin
          if (b[7:6] == 2'b10) begin
            handled = 1'b1;
            code_accum_nxt = {code_accum_nxt[25:0], b[5:0]};
            if (unit_count_nxt == 2'd0 &&
                ((cont_left_nxt == 2'd2 && code_accum_nxt < 32'h20) ||
                 (cont_left_nxt == 2'd3 && code_accum_nxt < 32'h10)))
              overlong_nxt = 1'b1;
            unit_count_nxt = unit_count_nxt + 2'd1;
            cont_left_nxt  = cont_left_nxt - 2'd1;
            if (cont_left_nxt == 2'd0) begin
              cp = code_accum_nxt;
              if (overlong_nxt || is_surr(cp) || cp == 32'hFFFE || cp == 32'hFFFF ||
                  cp > MAX_CP)
                cp = REPL_CP;
              code_accum_nxt = 32'd0;
              unit_count_nxt = 2'd0;
              overlong_nxt   = 1'b0;
              evt_nxt = push_cp(evt_nxt, cp);
            end
          end else begin
            // broken sequence: replace it, this byte starts a new character
            evt_nxt = push_cp(evt_nxt, REPL_CP);
            code_accum_nxt = 32'd0;
            cont_left_nxt  = 2'd0;
            unit_count_nxt = 2'd0;
            overlong_nxt   = 1'b0;
          end
        end
        if (!handled) begin
          if (b >= 8'hF8) begin
            evt_nxt = push_cp(evt_nxt, REPL_CP);
          end else if (b >= 8'hF0) begin
            code_accum_nxt = {29'd0, b[2:0]};
            cont_left_nxt  = 2'd3;
          end else if (b >= 8'hE0) begin
            code_accum_nxt = {28'd0, b[3:0]};
            cont_left_nxt  = 2'd2;
          end else if (b >= 8'hC0) begin
            code_accum_nxt = {27'd0, b[4:0]};
            cont_left_nxt  = 2'd1;
            overlong_nxt   = (b < 8'hC2);
          end else if (b >= 8'h80) begin
            evt_nxt = push_cp(evt_nxt, REPL_CP);
          end else begin
            evt_nxt = push_cp(evt_nxt, {24'd0, b});
          end
        end
      end
      FMT_UTF16, FMT_UTF16BE, FMT_UTF16LE, FMT_UCS2BE, FMT_UCS2LE,
      FMT_UTF32, FMT_UTF32BE, FMT_UTF32LE, FMT_UCS4BE, FMT_UCS4LE: begin
        size4 = (cfg.src_format == FMT_UTF32) || (cfg.src_format == FMT_UTF32BE) ||
                (cfg.src_format == FMT_UTF32LE) || (cfg.src_format == FMT_UCS4BE) ||
                (cfg.src_format == FMT_UCS4LE);
        cnt = {1'b0, unit_count_nxt} + 3'd1;
        code_accum_nxt = {code_accum_nxt[23:0], b};
        if (cnt < (size4 ? 3'd4 : 3'd2)) begin
          unit_count_nxt = cnt[1:0];
        end else begin
          raw = size4 ? code_accum_nxt : {16'd0, code_accum_nxt[15:0]};
          code_accum_nxt = 32'd0;
          unit_count_nxt = 2'd0;
          if (!started_nxt) begin
            if (cfg.src_format == FMT_UTF16)
              src_le_nxt = (raw == 32'h0000_FFFE) ? 1'b1 :
                           (raw == 32'h0000_FEFF) ? 1'b0 : cfg.native_little;
            else if (cfg.src_format == FMT_UTF32)
              src_le_nxt = (raw == 32'hFFFE_0000) ? 1'b1 :
                           (raw == 32'h0000_FEFF) ? 1'b0 : cfg.native_little;
            evt_nxt.mark = dst_generic;
          end
          started_nxt = 1'b1;
          if (cfg.src_format == FMT_UTF16 || cfg.src_format == FMT_UTF32)
            le = src_le_nxt;
          else
            le = (cfg.src_format == FMT_UTF16LE) || (cfg.src_format == FMT_UTF32LE) ||
                 (cfg.src_format == FMT_UCS2LE) || (cfg.src_format == FMT_UCS4LE);
          if (!le)
            v = raw;
          else if (size4)
            v = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
          else
            v = {16'd0, raw[7:0], raw[15:8]};
          if (cfg.src_format <= FMT_UTF16LE) begin
            if (have_high_nxt) begin
              have_high_nxt = 1'b0;
              if (v >= LOW_FIRST && v <= SURR_HI)
                evt_nxt = push_cp(evt_nxt, {11'd0, high_surr_nxt, v[9:0]} + PLANE1);
              else
                evt_nxt = push_cp(evt_nxt, REPL_CP);
              high_surr_nxt = 10'd0;
            end else if (!is_surr(v)) begin
              evt_nxt = push_cp(evt_nxt, v);
            end else if (v > HIGH_LAST) begin
              evt_nxt = push_cp(evt_nxt, REPL_CP);
            end else begin
              have_high_nxt = 1'b1;
              high_surr_nxt = v[9:0];
            end
          end else if (cfg.src_format <= FMT_UTF32LE) begin
            evt_nxt = push_cp(evt_nxt, (is_surr(v) || v > MAX_CP) ? REPL_CP : v);
          end else begin
            evt_nxt = push_cp(evt_nxt, v);
          end
        end
      end
      default: begin
      end
    endcase
    if (in_ch.in_last) begin
      if (cont_left_nxt != 2'd0 || unit_count_nxt != 2'd0 || have_high_nxt) begin
        if (!started_nxt) evt_nxt.mark = dst_generic;
        evt_nxt.trunc = 1'b1;
      end
      code_accum_nxt = 32'd0;
      cont_left_nxt  = 2'd0;
      unit_count_nxt = 2'd0;
      overlong_nxt   = 1'b0;
      high_surr_nxt  = 10'd0;
      have_high_nxt  = 1'b0;
      src_le_nxt     = 1'b0;
      started_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || stream_clear) begin
      code_accum_r <= '0;
      cont_left_r  <= '0;
      unit_count_r <= '0;
      overlong_r   <= 1'b0;
      high_surr_r  <= '0;
      have_high_r  <= 1'b0;
      src_le_r     <= 1'b0;
      started_r    <= 1'b0;
      evt_valid_r  <= 1'b0;
    end else begin
      if (evt_ready) evt_valid_r <= 1'b0;
      if (accept) begin
        code_accum_r <= code_accum_nxt;
        cont_left_r  <= cont_left_nxt;
        unit_count_r <= unit_count_nxt;
        overlong_r   <= overlong_nxt;
        high_surr_r  <= high_surr_nxt;
        have_high_r  <= have_high_nxt;
        src_le_r     <= src_le_nxt;
        started_r    <= started_nxt;
        if (evt_nxt.mark || evt_nxt.v0 || evt_nxt.v1 || evt_nxt.trunc) begin
          evt_valid_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) evt_r <= evt_nxt;
  end

`ifndef ASSERT_OFF
  a_evt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (evt_valid_r && !evt_ready && !stream_clear) |=> (evt_valid_r && $stable(evt_r)))
    else $error("event register changed while stalled");
  a_evt_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    evt_valid_r |-> (evt_r.mark || evt_r.v0 || evt_r.v1 || evt_r.trunc))
    else $error("empty event record queued");
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.in_last && !stream_clear) |=>
      (!started_r && cont_left_r == 2'd0 && unit_count_r == 2'd0 && !have_high_r))
    else $error("stream state survived end of text");
`endif

endmodule

`default_nettype wire

[rtl/core/utc_serializer.sv]
// utc_serializer: encodes each code point of an event record in the destination
// format and sends the bytes one per cycle while the sink is ready, through an output register.
// Depends on utc_pkg, utc_out_if.
`default_nettype none

module utc_serializer import utc_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  cfg_t        cfg,
  input  wire         evt_valid,
  input  evt_t        evt,
  output logic        evt_ready,
  utc_out_if.source   out_ch
);

  typedef struct packed {
    logic [3:0][7:0] bytes;   // bytes[0] goes out first
    logic [2:0]      nbytes;
  } enc_t;

  logic [3:0]  pend_r, pend_nxt;   // bit 0 mark, 1 cp0, 2 cp1, 3 truncation
  logic [31:0] cp0_r, cp1_r;
  logic [1:0]  idx_r, idx_nxt;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        char_end_r;
  logic        status_r;
  logic [3:0]  sel;
  logic [31:0] sym_cp;
  logic        sym_trunc;
  enc_t        enc;
  logic [2:0]  sym_len;
  logic        last_byte;
  logic        out_load;
  logic        emit;

  function automatic logic [1:0][7:0] ord16(input logic [15:0] w, input logic le);
    return le ? {w[15:8], w[7:0]} : {w[7:0], w[15:8]};
  endfunction

  function automatic logic [3:0][7:0] ord32(input logic [31:0] w, input logic le);
    return le ? {w[31:24], w[23:16], w[15:8], w[7:0]} : {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function automatic enc_t encode_cp(input logic [31:0] cp_in, input logic [3:0] dst,
                                     input logic native);
    enc_t        e;
    logic [31:0] cp;
    logic        le;
    logic [31:0] v;
    e  = '0;
    cp = cp_in;
    le = 1'b0;
    v  = 32'd0;
    unique case (dst)
      FMT_ASCII: begin
        e.nbytes   = 3'd1;
        e.bytes[0] = (cp > 32'h7F) ? QMARK : cp[7:0];
      end
      FMT_LATIN1: begin
        e.nbytes   = 3'd1;
        e.bytes[0] = (cp > 32'hFF) ? QMARK : cp[7:0];
      end
      FMT_UTF8: begin
        if (cp > MAX_CP || is_surr(cp)) cp = REPL_CP;
        if (cp <= 32'h7F) begin
          e.nbytes   = 3'd1;
          e.bytes[0] = cp[7:0];
        end else if (cp <= 32'h7FF) begin
          e.nbytes   = 3'd2;
          e.bytes[0] = {3'b110, cp[10:6]};
          e.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp <= 32'hFFFF) begin
          e.nbytes   = 3'd3;
          e.bytes[0] = {4'b1110, cp[15:12]};
          e.bytes[1] = {2'b10, cp[11:6]};
          e.bytes[2] = {2'b10, cp[5:0]};
        end else begin
          e.nbytes   = 3'd4;
          e.bytes[0] = {5'b11110, cp[20:18]};
          e.bytes[1] = {2'b10, cp[17:12]};
          e.bytes[2] = {2'b10, cp[11:6]};
          e.bytes[3] = {2'b10, cp[5:0]};
        end
      end
      FMT_UTF16, FMT_UTF16BE, FMT_UTF16LE: begin
        le = (dst == FMT_UTF16LE) || (dst == FMT_UTF16 && native);
        if (cp > MAX_CP || is_surr(cp)) cp = REPL_CP;
        if (cp < PLANE1) begin
          e.nbytes       = 3'd2;
          e.bytes[1:0]   = ord16(cp[15:0], le);
        end else begin
          v              = cp - PLANE1;
          e.nbytes       = 3'd4;
          e.bytes[1:0]   = ord16({6'b110110, v[19:10]}, le);
          e.bytes[3:2]   = ord16({6'b110111, v[9:0]}, le);
        end
      end
      FMT_UTF32, FMT_UTF32BE, FMT_UTF32LE: begin
        le = (dst == FMT_UTF32LE) || (dst == FMT_UTF32 && native);
        if (cp > MAX_CP || is_surr(cp)) cp = REPL_CP;
        e.nbytes = 3'd4;
        e.bytes  = ord32(cp, le);
      end
      FMT_UCS2BE, FMT_UCS2LE: begin
        if (cp > 32'hFFFF) cp = REPL_CP;
        e.nbytes     = 3'd2;
        e.bytes[1:0] = ord16(cp[15:0], dst == FMT_UCS2LE);
      end
      FMT_UCS4BE, FMT_UCS4LE: begin
        if (cp > UCS4_MAX) cp = REPL_CP;
        e.nbytes = 3'd4;
        e.bytes  = ord32(cp, dst == FMT_UCS4LE);
      end
      default: begin
      end
    endcase
    return e;
  endfunction

  // lowest pending symbol goes first
  assign sel      = pend_r & (~pend_r + 4'd1);
  assign out_load = !out_valid_r || out_ch.ready;

  always_comb begin
    sym_trunc = 1'b0;
    priority if (sel[0]) sym_cp = MARK_CP;
    else if (sel[1])     sym_cp = cp0_r;
    else if (sel[2])     sym_cp = cp1_r;
    else begin
      sym_cp    = 32'd0;
      sym_trunc = sel[3];
    end
  end

  assign enc       = encode_cp(sym_cp, cfg.dst_format, cfg.native_little);
  assign sym_len   = sym_trunc ? 3'd1 : enc.nbytes;
  assign last_byte = ({1'b0, idx_r} == sym_len - 3'd1);

  always_comb begin
    pend_nxt = pend_r;
    idx_nxt  = idx_r;
    emit     = 1'b0;
    if (pend_r != 4'd0) begin
      if (sym_len == 3'd0) begin
        // destination writes nothing for this symbol
        pend_nxt = pend_r & ~sel;
      end else if (out_load) begin
        emit = 1'b1;
        if (last_byte) begin
          pend_nxt = pend_r & ~sel;
          idx_nxt  = 2'd0;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
    end
  end

  assign evt_ready = (pend_nxt == 4'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      pend_r <= pend_nxt;
      if (evt_valid && evt_ready) pend_r <= {evt.trunc, evt.v1, evt.v0, evt.mark};
      if (emit) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_valid && evt_ready) begin
      cp0_r <= evt.cp0;
      cp1_r <= evt.cp1;
    end
    if (emit) begin
      out_byte_r <= sym_trunc ? 8'd0 : enc.bytes[idx_r];
      char_end_r <= !sym_trunc && last_byte;
      status_r   <= sym_trunc;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.char_end = char_end_r;
  assign out_ch.status   = status_r;

`ifndef ASSERT_OFF
  a_idx_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != 2'd0) |-> (pend_r != 4'd0))
    else $error("byte index set with nothing pending");
  a_trunc_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r) |-> (!char_end_r && out_byte_r == 8'd0))
    else $error("malformed truncation transaction");
  a_trunc_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && sym_trunc) |-> (pend_nxt == 4'd0))
    else $error("truncation sent before the end of its record");
`endif

endmodule

`default_nettype wire

[tb/sv/tb_unicode_transcoder.sv]
// tb_unicode_transcoder: self-checking testbench of the unicode transcoder.
// Depends on utc_pkg, utc_in_if, utc_out_if and unicode_transcoder.
`timescale 1ns / 100ps

module tb_unicode_transcoder;
  import utc_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       cend;
    logic       st;
  } dst_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [3:0] cfg_data = '0;

  utc_in_if in_ch ();
  utc_out_if out_ch ();

  unicode_transcoder dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #5 clk = ~clk;

  // predictor configuration and stream state
  logic [3:0]  p_src, p_dst;
  logic        p_native;
  logic [31:0] acc;
  logic [1:0]  cont_cnt, seen_cnt;
  logic        overlong, high_pend, order_le, text_open;
  logic [9:0]  high_bits;

  dst_byte_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;
  bit sink_calm = 1'b0;

  function automatic bit surr(logic [31:0] c);
    return c >= SURR_LO && c <= SURR_HI;
  endfunction

  task automatic push_byte(logic [7:0] b, logic e, logic s);
    dst_byte_t x;
    x.data = b;
    x.cend = e;
    x.st = s;
    expected_q.push_back(x);
  endtask

  task automatic push_word(logic [31:0] v, int nb, bit le, bit fin);
    int sh;
    for (int i = 0; i < nb; i++) begin
      sh = le ? 8 * i : 8 * (nb - 1 - i);
      push_byte(v >> sh, fin && i == nb - 1, 1'b0);
    end
  endtask

  task automatic encode_cp(logic [31:0] cp);
    logic [31:0] v;
    bit le;
    case (p_dst)
      FMT_ASCII: push_byte(cp > 32'h7F ? QMARK : cp[7:0], 1'b1, 1'b0);
      FMT_LATIN1: push_byte(cp > 32'hFF ? QMARK : cp[7:0], 1'b1, 1'b0);
      FMT_UTF8: begin
        if (cp > MAX_CP || surr(cp)) cp = REPL_CP;
        if (cp <= 32'h7F) push_byte(cp[7:0], 1, 0);
        else if (cp <= 32'h7FF) begin
          push_byte(8'hC0 | cp[10:6], 0, 0);
          push_byte(8'h80 | cp[5:0], 1, 0);
        end else if (cp <= 32'hFFFF) begin
          push_byte(8'hE0 | cp[15:12], 0, 0);
          push_byte(8'h80 | cp[11:6], 0, 0);
          push_byte(8'h80 | cp[5:0], 1, 0);
        end else begin
          push_byte(8'hF0 | cp[20:18], 0, 0);
          push_byte(8'h80 | cp[17:12], 0, 0);
          push_byte(8'h80 | cp[11:6], 0, 0);
          push_byte(8'h80 | cp[5:0], 1, 0);
        end
      end
      FMT_UTF16, FMT_UTF16BE, FMT_UTF16LE: begin
        le = p_dst == FMT_UTF16LE || (p_dst == FMT_UTF16 && p_native);
        if (cp > MAX_CP || surr(cp)) cp = REPL_CP;
        if (cp < PLANE1) push_word(cp, 2, le, 1);
        else begin
          v = cp - PLANE1;
          push_word(SURR_LO | v[19:10], 2, le, 0);
          push_word(LOW_FIRST | v[9:0], 2, le, 1);
        end
      end
      FMT_UTF32, FMT_UTF32BE, FMT_UTF32LE: begin
        le = p_dst == FMT_UTF32LE || (p_dst == FMT_UTF32 && p_native);
        if (cp > MAX_CP || surr(cp)) cp = REPL_CP;
        push_word(cp, 4, le, 1);
      end
      FMT_UCS2BE, FMT_UCS2LE: begin
        if (cp > 32'hFFFF) cp = REPL_CP;
        push_word(cp, 2, p_dst == FMT_UCS2LE, 1);
      end
      FMT_UCS4BE, FMT_UCS4LE: begin
        if (cp > UCS4_MAX) cp = REPL_CP;
        push_word(cp, 4, p_dst == FMT_UCS4LE, 1);
      end
      default: ;
    endcase
  endtask

  task automatic open_text();
    if (!text_open) begin
      if (p_dst == FMT_UTF16 || p_dst == FMT_UTF32) encode_cp(MARK_CP);
      text_open = 1'b1;
    end
  endtask

  task automatic clear_text();
    acc = '0; cont_cnt = '0; seen_cnt = '0; overlong = 0;
    high_bits = '0; high_pend = 0; order_le = 0; text_open = 0;
  endtask

  task automatic decode_utf8(logic [7:0] b);
    logic [31:0] cp;
    if (cont_cnt != 0) begin
      if (b[7:6] == 2'b10) begin
        acc = (acc << 6) | b[5:0];
        if (seen_cnt == 0 && ((cont_cnt == 2 && acc < 32'h20) ||
            (cont_cnt == 3 && acc < 32'h10))) overlong = 1;
        seen_cnt = seen_cnt + 1;
        cont_cnt = cont_cnt - 1;
        if (cont_cnt == 0) begin
          cp = acc;
          if (overlong || surr(cp) || cp == 32'hFFFE || cp == 32'hFFFF || cp > MAX_CP)
            cp = REPL_CP;
          acc = '0; seen_cnt = '0; overlong = 0;
          encode_cp(cp);
        end
        return;
      end
      encode_cp(REPL_CP);
      acc = '0; cont_cnt = '0; seen_cnt = '0; overlong = 0;
    end
    if (b >= 8'hF8) encode_cp(REPL_CP);
    else if (b >= 8'hF0) begin acc = b[2:0]; cont_cnt = 3; end
    else if (b >= 8'hE0) begin acc = b[3:0]; cont_cnt = 2; end
    else if (b >= 8'hC0) begin
      acc = b[4:0]; cont_cnt = 1; overlong = b < 8'hC2;
    end else if (b >= 8'h80) encode_cp(REPL_CP);
    else encode_cp(b);
  endtask

  task automatic decode_unit(logic [7:0] b, int size);
    logic [31:0] raw, v;
    bit le;
    acc = (acc << 8) | b;
    if (seen_cnt + 1 < size) begin
      seen_cnt = seen_cnt + 1;
      return;
    end
    raw = size == 2 ? (acc & 32'hFFFF) : acc;
    acc = '0; seen_cnt = '0;
    if (!text_open) begin
      if (p_src == FMT_UTF16)
        order_le = raw == 32'hFFFE ? 1 : (raw == 32'hFEFF ? 0 : p_native);
      else if (p_src == FMT_UTF32)
        order_le = raw == 32'hFFFE0000 ? 1 : (raw == 32'h0000FEFF ? 0 : p_native);
    end
    open_text();
    if (p_src == FMT_UTF16 || p_src == FMT_UTF32) le = order_le;
    else le = p_src == FMT_UTF16LE || p_src == FMT_UTF32LE ||
              p_src == FMT_UCS2LE || p_src == FMT_UCS4LE;
    if (!le) v = raw;
    else if (size == 2) v = {16'h0, raw[7:0], raw[15:8]};
    else v = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
    if (p_src <= FMT_UTF16LE) begin
      if (high_pend) begin
        high_pend = 0;
        if (v >= LOW_FIRST && v <= SURR_HI) encode_cp(({high_bits, v[9:0]}) + PLANE1);
        else encode_cp(REPL_CP);
        high_bits = '0;
      end else if (!surr(v)) encode_cp(v);
      else if (v > HIGH_LAST) encode_cp(REPL_CP);
      else begin
        high_pend = 1;
        high_bits = v[9:0];
      end
    end else if (p_src <= FMT_UTF32LE) encode_cp((surr(v) || v > MAX_CP) ? REPL_CP : v);
    else encode_cp(v);
  endtask

  task automatic predict_byte(logic [7:0] b, logic last);
    case (p_src)
      FMT_ASCII: begin open_text(); encode_cp(b[6:0]); end
      FMT_LATIN1: begin open_text(); encode_cp(b); end
      FMT_UTF8: begin open_text(); decode_utf8(b); end
      FMT_UTF16, FMT_UTF16BE, FMT_UTF16LE, FMT_UCS2BE, FMT_UCS2LE: decode_unit(b, 2);
      FMT_UTF32, FMT_UTF32BE, FMT_UTF32LE, FMT_UCS4BE, FMT_UCS4LE: decode_unit(b, 4);
      default: ;
    endcase
    if (last) begin
      if (cont_cnt != 0 || seen_cnt != 0 || high_pend) begin
        open_text();
        push_byte(8'h00, 0, 1);
      end
      clear_text();
    end
  endtask

  // called at a falling edge; the input goes idle here
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [3:0] val);
    wait_drained();
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SRC_FORMAT: p_src = val;
      CFG_DST_FORMAT: p_dst = val;
      CFG_NATIVE_LITTLE: p_native = val[0];
      default: return;
    endcase
    clear_text();
  endtask

  task automatic set_formats(logic [3:0] s, logic [3:0] d, logic nl);
    write_reg(CFG_SRC_FORMAT, s);
    write_reg(CFG_DST_FORMAT, d);
    write_reg(CFG_NATIVE_LITTLE, {3'b0, nl});
  endtask

  // called at a falling edge; returns at a falling edge with valid still high
  task automatic send_byte(logic [7:0] b, logic last);
    while (!calm && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1; in_ch.in_byte <= b; in_ch.in_last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_byte(b, last);
    @(negedge clk);
  endtask

  // result sink: random stalls, compare at the rising edge
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= sink_calm || $urandom_range(99) >= 6;
    end
  end

  always @(posedge clk) begin
    dst_byte_t got, want;
    cycles <= cycles + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.data = out_ch.out_byte;
      got.cend = out_ch.char_end;
      got.st = out_ch.status;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected transaction %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected byte %h end %b st %b, got byte %h end %b st %b",
                     want.data, want.cend, want.st, got.data, got.cend, got.st);
        end
      end
    end
  end

  initial begin
    wait (cycles >= 400000);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic test_directed_utf8();
    logic [7:0] seq[] = '{8'h41, 8'h00, 8'h7F, 8'hC3, 8'hA9, 8'hC0, 8'h80, 8'hE2,
                          8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'h80, 8'hFF,
                          8'hE0, 8'h80, 8'h80, 8'hED, 8'hA0, 8'h80, 8'hC3, 8'h41,
                          8'hE2};
    set_formats(FMT_UTF8, FMT_UTF16, 1);
    foreach (seq[i]) send_byte(seq[i], i == seq.size() - 1);
  endtask

  task automatic test_directed_utf16();
    logic [7:0] seq[] = '{8'hFE, 8'hFF, 8'hD8, 8'h3D, 8'hDE, 8'h00, 8'hDC, 8'h00,
                          8'hD8, 8'h00, 8'h00, 8'h41, 8'hD8, 8'h00};
    set_formats(FMT_UTF16, FMT_UTF8, 0);
    foreach (seq[i]) send_byte(seq[i], i == seq.size() - 1);
    set_formats(FMT_UTF32, FMT_UTF32, 0);
    send_byte(8'hFF, 0); send_byte(8'hFE, 0); send_byte(8'h00, 0); send_byte(8'h00, 0);
    send_byte(8'hFF, 0); send_byte(8'hFF, 0); send_byte(8'hFF, 0); send_byte(8'hFF, 1);
    set_formats(FMT_UCS4BE, FMT_ASCII, 1);
    send_byte(8'h7F, 0); send_byte(8'hFF, 0); send_byte(8'hFF, 0); send_byte(8'hFF, 1);
    write_reg(2'd3, 4'hF);
    set_formats(4'd15, 4'd15, 1);
    send_byte(8'h41, 1);
  endtask

  task automatic test_pause_drain();
    set_formats(FMT_LATIN1, FMT_UTF16, 1);
    send_byte(8'hE9, 0);
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    @(negedge clk);
    send_byte(8'h41, 1);
  endtask

  function automatic logic [7:0] utf8_rand_byte();
    int k = $urandom_range(9);
    if (k < 4) return $urandom_range(8'h7F);
    if (k < 7) return 8'h80 | $urandom_range(8'h3F);
    if (k == 7) return 8'hC0 | $urandom_range(8'h3F);
    return $urandom_range(255);
  endfunction

  task automatic test_random();
    logic [3:0] s, d;
    for (int ph = 0; ph < 8; ph++) begin
      s = $urandom_range(ph == 7 ? 15 : 12);
      d = ph == 0 ? 4'd0 : ph == 1 ? 4'd12 : $urandom_range(ph == 6 ? 15 : 12);
      set_formats(s, d, $urandom_range(1));
      calm = ph == 3;
      sink_calm = ph == 3;
      for (int i = 0; i < 12; i++)
        send_byte(s == FMT_UTF8 ? utf8_rand_byte() : $urandom_range(255),
                  $urandom_range(15) == 0);
    end
    calm = 0;
    sink_calm = 0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    in_ch.in_last = 1'b0;
    p_src = FMT_UTF8; p_dst = FMT_UTF8; p_native = 1;
    clear_text();
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    test_directed_utf8();
    test_directed_utf16();
    test_pause_drain();
    test_random();
    wait_drained();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
